>>> rtl/raabb_pkg.sv
// ----------------------------------------------------------------------------
// raabb_pkg
// Shared constants and types for the ray / box slab intersection block.
// ----------------------------------------------------------------------------
package raabb_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int REG_IDX_W   = 3;

  // saturation bound of the slab parameter
  localparam logic signed [63:0] T_INF   = 64'sh4000_0000_0000_0000;
  localparam logic [62:0]        T_INF_U = 63'h4000_0000_0000_0000;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_HULL  = 3'd0,
    REG_MIN_X = 3'd1,
    REG_MIN_Y = 3'd2,
    REG_MIN_Z = 3'd3,
    REG_MAX_X = 3'd4,
    REG_MAX_Y = 3'd5,
    REG_MAX_Z = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    FACE_NONE  = 3'd0,
    FACE_NEG_X = 3'd1,
    FACE_POS_X = 3'd2,
    FACE_NEG_Y = 3'd3,
    FACE_POS_Y = 3'd4,
    FACE_NEG_Z = 3'd5,
    FACE_POS_Z = 3'd6
  } face_t;

  typedef struct packed {
    logic nonempty;
    logic full;
  } qstat_t;

endpackage

>>> rtl/ray_aabb_slab_intersect.sv
// ----------------------------------------------------------------------------
// ray_aabb_slab_intersect
// Ray from start through end point against axis-aligned box, slab test in signed fixed point.
// ----------------------------------------------------------------------------
// Takes one request per clock while in_stall is low and out_stall does not hold
// the pipeline, and returns one result per request, in order. Each request
// passes a short queue and then a fully pipelined datapath that holds the six
// bit-per-stage slab dividers. Config registers are to be written through
// cfg_write / cfg_index / cfg_data only while no request is in flight; the
// block itself does not enforce this.
module ray_aabb_slab_intersect #(
  parameter int COORD_WIDTH = raabb_pkg::COORD_WIDTH,
  parameter int FRAC_BITS   = raabb_pkg::FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [raabb_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [COORD_WIDTH-1:0]         cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [COORD_WIDTH-1:0]         ray_start_x,
  input  logic [COORD_WIDTH-1:0]         ray_start_y,
  input  logic [COORD_WIDTH-1:0]         ray_start_z,
  input  logic [COORD_WIDTH-1:0]         ray_end_x,
  input  logic [COORD_WIDTH-1:0]         ray_end_y,
  input  logic [COORD_WIDTH-1:0]         ray_end_z,
  input  logic [COORD_WIDTH-1:0]         box_pos_x,
  input  logic [COORD_WIDTH-1:0]         box_pos_y,
  input  logic [COORD_WIDTH-1:0]         box_pos_z,
  input  logic                           box_enabled,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           hit,
  output logic [COORD_WIDTH-1:0]         hit_x,
  output logic [COORD_WIDTH-1:0]         hit_y,
  output logic [COORD_WIDTH-1:0]         hit_z,
  output logic [2:0]                     face_code
);

  localparam int CW = COORD_WIDTH;
  localparam int EW = 12 * CW + 10;

  logic                 hull_present;
  logic [2:0][CW-1:0]   ext_min;
  logic [2:0][CW-1:0]   ext_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      hull_present <= 1'b0;
      ext_min      <= '0;
      ext_max      <= '0;
    end else if (cfg_write) begin
      case (raabb_pkg::reg_idx_t'(cfg_index))
        raabb_pkg::REG_HULL:  hull_present <= cfg_data[0];
        raabb_pkg::REG_MIN_X: ext_min[0]   <= cfg_data;
        raabb_pkg::REG_MIN_Y: ext_min[1]   <= cfg_data;
        raabb_pkg::REG_MIN_Z: ext_min[2]   <= cfg_data;
        raabb_pkg::REG_MAX_X: ext_max[0]   <= cfg_data;
        raabb_pkg::REG_MAX_Y: ext_max[1]   <= cfg_data;
        raabb_pkg::REG_MAX_Z: ext_max[2]   <= cfg_data;
        default: ;
      endcase
    end
  end

  raabb_pkg::qstat_t qstat;
  logic              push;
  logic              pop;
  logic [EW-1:0]     entry_in;
  logic [EW-1:0]     entry_out;

  raabb_front #(.CW(CW), .EW(EW)) u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .ray_start    ({ray_start_z, ray_start_y, ray_start_x}),
    .ray_end      ({ray_end_z, ray_end_y, ray_end_x}),
    .box_pos      ({box_pos_z, box_pos_y, box_pos_x}),
    .box_enabled  (box_enabled),
    .hull_present (hull_present),
    .ext_min      (ext_min),
    .ext_max      (ext_max),
    .qstat        (qstat),
    .push         (push),
    .entry        (entry_in)
  );

  raabb_queue #(.W(EW)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (entry_in),
    .pop   (pop),
    .dout  (entry_out),
    .qstat (qstat)
  );

  raabb_back #(.CW(CW), .FB(FRAC_BITS), .EW(EW)) u_back (
    .clk       (clk),
    .rst       (rst),
    .entry     (entry_out),
    .qstat     (qstat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .hit       (hit),
    .hit_x     (hit_x),
    .hit_y     (hit_y),
    .hit_z     (hit_z),
    .face_code (face_code)
  );

endmodule

>>> rtl/raabb_front.sv
// ----------------------------------------------------------------------------
// raabb_front
// Request intake: forms box corners and ray direction, flags disabled
// boxes and missing hulls, and pushes the request into the queue.
// ----------------------------------------------------------------------------
module raabb_front #(
  parameter int CW = raabb_pkg::COORD_WIDTH,
  parameter int EW = 12 * CW + 10
) (
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [2:0][CW-1:0]     ray_start,
  input  logic [2:0][CW-1:0]     ray_end,
  input  logic [2:0][CW-1:0]     box_pos,
  input  logic                   box_enabled,
  input  logic                   hull_present,
  input  logic [2:0][CW-1:0]     ext_min,
  input  logic [2:0][CW-1:0]     ext_max,
  input  raabb_pkg::qstat_t      qstat,
  output logic                   push,
  output logic [EW-1:0]          entry
);

  typedef struct packed {
    logic                ok;
    logic [2:0][CW-1:0]  s;
    logic [2:0][CW:0]    d;
    logic [2:0][CW:0]    wmin;
    logic [2:0][CW:0]    wmax;
  } entry_t;

  entry_t e;

  always_comb begin
    e.ok = hull_present & box_enabled;
    for (int a = 0; a < 3; a++) begin
      e.s[a]    = ray_start[a];
      e.d[a]    = {ray_end[a][CW-1], ray_end[a]} - {ray_start[a][CW-1], ray_start[a]};
      e.wmin[a] = {box_pos[a][CW-1], box_pos[a]} + {ext_min[a][CW-1], ext_min[a]};
      e.wmax[a] = {box_pos[a][CW-1], box_pos[a]} + {ext_max[a][CW-1], ext_max[a]};
    end
  end

  assign entry    = e;
  assign in_stall = qstat.full;
  assign push     = in_valid & ~qstat.full;

endmodule

>>> rtl/raabb_queue.sv
// ----------------------------------------------------------------------------
// raabb_queue
// Short request queue between intake and the arithmetic pipeline.
// ----------------------------------------------------------------------------
module raabb_queue #(
  parameter int W     = 394,
  parameter int DEPTH = raabb_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [W-1:0]      din,
  input  logic              pop,
  output logic [W-1:0]      dout,
  output raabb_pkg::qstat_t qstat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [W-1:0]    mem [0:DEPTH-1];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CNTW-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CNTW'(1);
      end else if (pop && !push) begin
        count <= count - CNTW'(1);
      end
    end
  end

  assign dout           = mem[rd_ptr];
  assign qstat.nonempty = (count != '0);
  assign qstat.full     = (count == CNTW'(DEPTH));

endmodule

>>> rtl/raabb_div.sv
// ----------------------------------------------------------------------------
// raabb_div
// Pipelined restoring divider, one quotient bit per stage. Gives the slab
// parameter num * 2^FB / den, truncated toward zero, magnitude saturated.
// ----------------------------------------------------------------------------
module raabb_div #(
  parameter int CW = raabb_pkg::COORD_WIDTH,
  parameter int FB = raabb_pkg::FRAC_BITS
) (
  input  logic                clk,
  input  logic                en,
  input  logic [CW+1:0]       num,
  input  logic [CW:0]         den,
  output logic signed [63:0]  q
);

  localparam int NW     = CW + 2;
  localparam int DW     = NW + FB;
  localparam int RW     = CW + 2;
  localparam int XW     = (DW > 64) ? DW : 64;
  localparam int SAT_SH = 62 - FB;

  logic [RW-1:0] rem [0:DW];
  logic [DW-1:0] dq  [0:DW];
  logic [CW:0]   dn  [0:DW];
  logic          ng  [0:DW];
  logic          st  [0:DW];

  logic [NW-1:0] nmag;
  logic [CW:0]   dmag;
  logic [XW-1:0] qx;
  logic [62:0]   qm;

  assign nmag = num[NW-1] ? NW'(-num) : num;
  assign dmag = den[CW] ? (CW+1)'(-den) : den;

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= '0;
      dq[0]  <= {nmag, {FB{1'b0}}};
      dn[0]  <= dmag;
      ng[0]  <= num[NW-1] ^ den[CW];
      st[0]  <= ((nmag >> SAT_SH) != '0);
    end
  end

  for (genvar k = 1; k <= DW; k++) begin : g_step
    logic [RW-1:0] trial;
    logic          ge;
    assign trial = {rem[k-1][RW-2:0], dq[k-1][DW-1]};
    assign ge    = (trial >= RW'(dn[k-1]));
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? trial - RW'(dn[k-1]) : trial;
        dq[k]  <= {dq[k-1][DW-2:0], ge};
        dn[k]  <= dn[k-1];
        ng[k]  <= ng[k-1];
        st[k]  <= st[k-1];
      end
    end
  end

  assign qx = XW'(dq[DW]);
  assign qm = (st[DW] || qx > XW'(raabb_pkg::T_INF_U)) ? raabb_pkg::T_INF_U : qx[62:0];

  always_ff @(posedge clk) begin
    if (en) begin
      q <= ng[DW] ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
    end
  end

endmodule

>>> rtl/raabb_back.sv
// ----------------------------------------------------------------------------
// raabb_back
// Arithmetic pipeline: slab divisions, interval merge, entry point
// multiply, face match and the result register.
// ----------------------------------------------------------------------------
module raabb_back #(
  parameter int CW = raabb_pkg::COORD_WIDTH,
  parameter int FB = raabb_pkg::FRAC_BITS,
  parameter int EW = 12 * CW + 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [EW-1:0]      entry,
  input  raabb_pkg::qstat_t  qstat,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               hit,
  output logic [CW-1:0]      hit_x,
  output logic [CW-1:0]      hit_y,
  output logic [CW-1:0]      hit_z,
  output logic [2:0]         face_code
);

  localparam int NW = CW + 2;
  localparam int DW = NW + FB;
  localparam int DL = DW + 2;
  localparam int VW = 65;
  localparam int PW = CW + 64;
  localparam longint unsigned NEAR_LIM = ((64'd1 << FB) - 64'd1) / 64'd10000;
  localparam logic signed [VW-1:0] CMAX = {{(VW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [VW-1:0] CMIN = {{(VW-CW+1){1'b1}}, {(CW-1){1'b0}}};

  typedef struct packed {
    logic                ok;
    logic [2:0][CW-1:0]  s;
    logic [2:0][CW:0]    d;
    logic [2:0][CW:0]    wmin;
    logic [2:0][CW:0]    wmax;
  } entry_t;

  typedef struct packed {
    logic                ok;
    logic [2:0]          dz;
    logic [2:0][CW-1:0]  s;
    logic [2:0][CW:0]    d;
    logic [2:0][CW:0]    wmin;
    logic [2:0][CW:0]    wmax;
  } sb_t;

  logic adv;
  entry_t e;

  assign adv = ~out_valid | ~out_stall;
  assign pop = adv & qstat.nonempty;
  assign e   = entry;

  // prep: numerators and zero-direction slab test
  logic [2:0][NW-1:0] nlo, nhi;
  logic [2:0]         dz, in_slab;
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic signed [CW:0] flo, fhi, sx;
      sx      = $signed({e.s[a][CW-1], e.s[a]});
      flo     = ($signed(e.wmin[a]) < $signed(e.wmax[a])) ? $signed(e.wmin[a])
                                                           : $signed(e.wmax[a]);
      fhi     = ($signed(e.wmin[a]) < $signed(e.wmax[a])) ? $signed(e.wmax[a])
                                                           : $signed(e.wmin[a]);
      nlo[a]  = {e.wmin[a][CW], e.wmin[a]} - {{2{e.s[a][CW-1]}}, e.s[a]};
      nhi[a]  = {e.wmax[a][CW], e.wmax[a]} - {{2{e.s[a][CW-1]}}, e.s[a]};
      dz[a]   = (e.d[a] == '0);
      in_slab[a] = (sx >= flo) && (sx <= fhi);
    end
  end

  logic               p_v;
  sb_t                p_sb;
  logic [2:0][NW-1:0] p_nlo, p_nhi;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_v <= 1'b0;
    end else if (adv) begin
      p_v <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_sb.ok   <= e.ok & ((~dz | in_slab) == 3'b111);
      p_sb.dz   <= dz;
      p_sb.s    <= e.s;
      p_sb.d    <= e.d;
      p_sb.wmin <= e.wmin;
      p_sb.wmax <= e.wmax;
      p_nlo     <= nlo;
      p_nhi     <= nhi;
    end
  end

  // slab divisions
  logic [2:0][63:0] q_lo, q_hi;
  for (genvar a = 0; a < 3; a++) begin : g_div
    raabb_div #(.CW(CW), .FB(FB)) u_div_lo (
      .clk (clk), .en (adv), .num (p_nlo[a]), .den (p_sb.d[a]), .q (q_lo[a])
    );
    raabb_div #(.CW(CW), .FB(FB)) u_div_hi (
      .clk (clk), .en (adv), .num (p_nhi[a]), .den (p_sb.d[a]), .q (q_hi[a])
    );
  end

  // sideband alongside the dividers
  logic [DL-1:0] sb_v;
  sb_t           sb [0:DL-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sb_v <= '0;
    end else if (adv) begin
      sb_v <= {sb_v[DL-2:0], p_v};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb[0] <= p_sb;
      for (int k = 1; k < DL; k++) begin
        sb[k] <= sb[k-1];
      end
    end
  end

  // per-axis interval
  logic               c1_v;
  sb_t                c1_sb;
  logic [2:0][63:0]   c1_lo, c1_hi;
  logic [2:0][63:0]   lo_n, hi_n;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (sb[DL-1].dz[a]) begin
        lo_n[a] = -raabb_pkg::T_INF;
        hi_n[a] = raabb_pkg::T_INF;
      end else if ($signed(q_lo[a]) > $signed(q_hi[a])) begin
        lo_n[a] = q_hi[a];
        hi_n[a] = q_lo[a];
      end else begin
        lo_n[a] = q_lo[a];
        hi_n[a] = q_hi[a];
      end
    end
  end

  // interval merge
  logic               c2_v;
  sb_t                c2_sb;
  logic [62:0]        c2_tn;
  logic signed [63:0] tn, tf;
  logic               c2_ok_n;

  always_comb begin
    tn = $signed(c1_lo[0]);
    tf = $signed(c1_hi[0]);
    for (int a = 1; a < 3; a++) begin
      if ($signed(c1_lo[a]) > tn) begin
        tn = $signed(c1_lo[a]);
      end
      if ($signed(c1_hi[a]) < tf) begin
        tf = $signed(c1_hi[a]);
      end
    end
    c2_ok_n = c1_sb.ok & ~(tn > tf) & ~(tn < 0);
  end

  // entry point: partial products, sum, scale, offset
  logic                   m1_v, m2_v, m3_v, m4_v;
  sb_t                    m1_sb, m2_sb, m3_sb, m4_sb;
  logic [2:0][CW+32:0]    m1_pl;
  logic [2:0][CW+31:0]    m1_ph;
  logic [2:0][PW-1:0]     m2_sum;
  logic [2:0][62:0]       m3_r;
  logic [2:0][CW-1:0]     m4_p;
  logic [2:0][CW:0]       dmag;
  logic [2:0][62:0]       r_n;
  logic [2:0][CW-1:0]     p_n;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic [PW-1:0]         sh;
      logic signed [VW-1:0]  v, rs;
      dmag[a] = c2_sb.d[a][CW] ? (CW+1)'(-c2_sb.d[a]) : c2_sb.d[a];
      sh      = m2_sum[a] >> FB;
      r_n[a]  = (sh > PW'(raabb_pkg::T_INF_U)) ? raabb_pkg::T_INF_U : sh[62:0];
      rs      = $signed({2'b00, m3_r[a]});
      v       = $signed({{(VW-CW){m3_sb.s[a][CW-1]}}, m3_sb.s[a]})
                + (m3_sb.d[a][CW] ? -rs : rs);
      if (v > CMAX) begin
        p_n[a] = CMAX[CW-1:0];
      end else if (v < CMIN) begin
        p_n[a] = CMIN[CW-1:0];
      end else begin
        p_n[a] = v[CW-1:0];
      end
    end
  end

  // face match
  logic [2:0]           near_min, near_max;
  raabb_pkg::face_t     face;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic signed [CW+1:0] dmn, dmx;
      logic [CW+1:0]        amn, amx;
      dmn = $signed({{2{m4_p[a][CW-1]}}, m4_p[a]}) - $signed({m4_sb.wmin[a][CW], m4_sb.wmin[a]});
      dmx = $signed({{2{m4_p[a][CW-1]}}, m4_p[a]}) - $signed({m4_sb.wmax[a][CW], m4_sb.wmax[a]});
      amn = dmn[CW+1] ? (CW+2)'(-dmn) : dmn;
      amx = dmx[CW+1] ? (CW+2)'(-dmx) : dmx;
      near_min[a] = (amn <= (CW+2)'(NEAR_LIM));
      near_max[a] = (amx <= (CW+2)'(NEAR_LIM));
    end
    face = raabb_pkg::FACE_NONE;
    if (near_max[2]) face = raabb_pkg::FACE_POS_Z;
    if (near_min[2]) face = raabb_pkg::FACE_NEG_Z;
    if (near_max[1]) face = raabb_pkg::FACE_POS_Y;
    if (near_min[1]) face = raabb_pkg::FACE_NEG_Y;
    if (near_max[0]) face = raabb_pkg::FACE_POS_X;
    if (near_min[0]) face = raabb_pkg::FACE_NEG_X;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_v      <= 1'b0;
      c2_v      <= 1'b0;
      m1_v      <= 1'b0;
      m2_v      <= 1'b0;
      m3_v      <= 1'b0;
      m4_v      <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      c1_v      <= sb_v[DL-1];
      c2_v      <= c1_v;
      m1_v      <= c2_v;
      m2_v      <= m1_v;
      m3_v      <= m2_v;
      m4_v      <= m3_v;
      out_valid <= m4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c1_sb    <= sb[DL-1];
      c1_lo    <= lo_n;
      c1_hi    <= hi_n;
      c2_sb    <= '{ok: c2_ok_n, dz: c1_sb.dz, s: c1_sb.s, d: c1_sb.d,
                    wmin: c1_sb.wmin, wmax: c1_sb.wmax};
      c2_tn    <= tn[62:0];
      m1_sb    <= c2_sb;
      for (int a = 0; a < 3; a++) begin
        m1_pl[a]  <= dmag[a] * c2_tn[31:0];
        m1_ph[a]  <= dmag[a] * c2_tn[62:32];
        m2_sum[a] <= PW'(m1_pl[a]) + (PW'(m1_ph[a]) << 32);
      end
      m2_sb     <= m1_sb;
      m3_sb     <= m2_sb;
      m3_r      <= r_n;
      m4_sb     <= m3_sb;
      m4_p      <= p_n;
      hit       <= m4_sb.ok;
      hit_x     <= m4_sb.ok ? m4_p[0] : '0;
      hit_y     <= m4_sb.ok ? m4_p[1] : '0;
      hit_z     <= m4_sb.ok ? m4_p[2] : '0;
      face_code <= m4_sb.ok ? face : raabb_pkg::FACE_NONE;
    end
  end

endmodule

>>> rtl/raabb_chk.sv
// ----------------------------------------------------------------------------
// raabb_chk
// Port-level checks for the ray / box slab intersection block.
// ----------------------------------------------------------------------------
module raabb_chk #(
  parameter int CW = raabb_pkg::COORD_WIDTH
) (
  input logic          clk,
  input logic          rst,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input logic          hit,
  input logic [CW-1:0] hit_x,
  input logic [CW-1:0] hit_y,
  input logic [CW-1:0] hit_z,
  input logic [2:0]    face_code
);

  // a miss carries no point and no face
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> hit_x == '0 && hit_y == '0 && hit_z == '0 &&
                          face_code == raabb_pkg::FACE_NONE)
    else $error("miss result with nonzero payload");

  // pipeline empties on reset
  a_rst_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // queue empties on reset
  a_rst_in: assert property (@(posedge clk) rst |=> !in_stall)
    else $error("intake stalled right after reset");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid &&
      $stable({hit, hit_x, hit_y, hit_z, face_code}))
    else $error("stalled result changed");

endmodule

bind ray_aabb_slab_intersect raabb_chk #(.CW(COORD_WIDTH)) u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .hit       (hit),
  .hit_x     (hit_x),
  .hit_y     (hit_y),
  .hit_z     (hit_z),
  .face_code (face_code)
);
